// ----- hw/rtl/gmc_pkg.sv -----
// shared constants and request codes for the graph m-coloring search
// no dependencies
package gmc_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int COLOR_BITS   = 4;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COLORING_W   = 32;
  localparam int CFG_W        = 4;

  typedef logic [1:0]              func_t;
  typedef logic [VTX_W-1:0]        vtx_t;
  typedef logic [MAX_VERTICES-1:0] adj_row_t;
  typedef logic [COLOR_BITS-1:0]   color_t;

  localparam func_t FUNC_CLEAR = 2'd0;
  localparam func_t FUNC_EDGE  = 2'd1;
  localparam func_t FUNC_NEXT  = 2'd2;
  localparam func_t FUNC_NONE  = 2'd3;

  localparam logic CFG_NUM_VERTICES = 1'b0;
  localparam logic CFG_NUM_COLORS   = 1'b1;

endpackage

// ----- hw/rtl/gmc_adj_ram.sv -----
// adjacency store: one neighbor mask per vertex, synchronous read with a registered output
// per-row valid bits give the all-zero state after reset or a clear
// depends on gmc_pkg
module gmc_adj_ram (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             we,
  input  gmc_pkg::vtx_t     waddr,
  input  gmc_pkg::adj_row_t wdata,
  input  logic             re,
  input  gmc_pkg::vtx_t     raddr,
  output gmc_pkg::adj_row_t rdata
);

  gmc_pkg::adj_row_t mem [gmc_pkg::MAX_VERTICES];
  logic [gmc_pkg::MAX_VERTICES-1:0] valid_r;
  gmc_pkg::adj_row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  // read returns the old row on a same-cycle write to the same entry
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= valid_r[raddr] ? mem[raddr] : '0;
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/gmc_clash.sv -----
// neighbor color check for one candidate color of the current vertex
// depends on gmc_pkg
module gmc_clash (
  input  gmc_pkg::adj_row_t                                      adj_row,
  input  logic [gmc_pkg::MAX_VERTICES*gmc_pkg::COLOR_BITS-1:0]   colors,
  input  gmc_pkg::color_t                                        cand,
  input  logic [gmc_pkg::CNT_W-1:0]                              n_used,
  output logic                                                   clash
);

  logic [gmc_pkg::MAX_VERTICES-1:0] hit;

  always_comb begin
    for (int j = 0; j < gmc_pkg::MAX_VERTICES; j++) begin
      hit[j] = adj_row[j] && (j < int'(n_used)) &&
               (colors[j*gmc_pkg::COLOR_BITS +: gmc_pkg::COLOR_BITS] == cand);
    end
  end

  assign clash = |hit;

endmodule

// ----- hw/rtl/graph_m_coloring_search.sv -----
// find next: one adjacency row read per depth step, then color trials against the held row
// throughput: one request at a time; the next is taken once the result is registered,
//   and a result still waiting on out_tready holds the search at its reply
// reset: rst_n synchronous, active low; no edges, all vertices uncolored, search at vertex 0
// depends on gmc_pkg, gmc_adj_ram, gmc_clash
module graph_m_coloring_search (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // func[1:0], vertex_a[4:2], vertex_b[7:5]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // coloring[31:0]
  output logic [1:0]  out_tuser,  // found[0], exhausted[1]
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata
);

  localparam int NV = gmc_pkg::MAX_VERTICES;
  localparam int CB = gmc_pkg::COLOR_BITS;

  // controller states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_EDGE_A   = 3'd2;
  localparam logic [2:0] S_EDGE_B   = 3'd3;
  localparam logic [2:0] S_SRCH_RD  = 3'd4;
  localparam logic [2:0] S_SRCH_TRY = 3'd5;
  localparam logic [2:0] S_REPLY    = 3'd6;

  logic [2:0] state_r, state_nxt;

  // latched request
  gmc_pkg::func_t func_r, func_nxt;
  gmc_pkg::vtx_t  va_r, va_nxt;
  gmc_pkg::vtx_t  vb_r, vb_nxt;

  // configuration
  logic [gmc_pkg::CFG_W-1:0] num_vertices_r, num_vertices_nxt;
  logic [gmc_pkg::CFG_W-1:0] num_colors_r, num_colors_nxt;

  // search state
  gmc_pkg::color_t color_r [NV];
  gmc_pkg::color_t color_nxt [NV];
  gmc_pkg::vtx_t   depth_r, depth_nxt;
  logic            done_r, done_nxt;

  // result register
  logic                             out_valid_r, out_valid_nxt;
  logic                             found_r, found_nxt;
  logic                             exh_r, exh_nxt;
  logic [gmc_pkg::COLORING_W-1:0]   coloring_r, coloring_nxt;

  // adjacency store port
  logic              adj_clr, adj_we, adj_re;
  gmc_pkg::vtx_t     adj_waddr, adj_raddr;
  gmc_pkg::adj_row_t adj_wdata, adj_rdata;

  // derived values
  logic [gmc_pkg::CNT_W-1:0] n_used;
  gmc_pkg::vtx_t             n_last;
  logic [CB:0]               cand_wide;
  gmc_pkg::color_t           cand;
  logic [NV*CB-1:0]          trial_colors;
  logic                      clash;
  logic                      out_free;
  logic                      in_fire;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = coloring_r;
  assign out_tuser  = {exh_r, found_r};

  // vertex count 0 acts as 1, counts above the store size act as the store size
  always_comb begin
    if (num_vertices_r == '0) begin
      n_used = gmc_pkg::CNT_W'(1);
    end else if (int'(num_vertices_r) > NV) begin
      n_used = gmc_pkg::CNT_W'(NV);
    end else begin
      n_used = gmc_pkg::CNT_W'(num_vertices_r);
    end
  end
  assign n_last = gmc_pkg::VTX_W'(n_used - gmc_pkg::CNT_W'(1));

  // next color for the current vertex; wraps to 0 past num_colors
  assign cand_wide = {1'b0, color_r[depth_r]} + (CB+1)'(1);
  assign cand = (cand_wide > (CB+1)'(num_colors_r)) ? '0 : cand_wide[CB-1:0];

  // colors as they stand with the candidate placed at the current vertex,
  // vertices beyond the used count read 0
  always_comb begin
    for (int i = 0; i < NV; i++) begin
      if (i >= int'(n_used)) begin
        trial_colors[i*CB +: CB] = '0;
      end else if (gmc_pkg::VTX_W'(i) == depth_r) begin
        trial_colors[i*CB +: CB] = cand;
      end else begin
        trial_colors[i*CB +: CB] = color_r[i];
      end
    end
  end

  gmc_adj_ram u_adj (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (adj_clr),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  gmc_clash u_clash (
    .adj_row (adj_rdata),
    .colors  (trial_colors),
    .cand    (cand),
    .n_used  (n_used),
    .clash   (clash)
  );

  always_comb begin
    state_nxt        = state_r;
    func_nxt         = func_r;
    va_nxt           = va_r;
    vb_nxt           = vb_r;
    num_vertices_nxt = num_vertices_r;
    num_colors_nxt   = num_colors_r;
    depth_nxt        = depth_r;
    done_nxt         = done_r;
    out_valid_nxt    = out_valid_r;
    found_nxt        = found_r;
    exh_nxt          = exh_r;
    coloring_nxt     = coloring_r;
    adj_clr          = 1'b0;
    adj_we           = 1'b0;
    adj_re           = 1'b0;
    adj_waddr        = va_r;
    adj_wdata        = '0;
    adj_raddr        = va_r;
    for (int i = 0; i < NV; i++) begin
      color_nxt[i] = color_r[i];
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          func_nxt  = in_tdata[1:0];
          va_nxt    = in_tdata[4:2];
          vb_nxt    = in_tdata[7:5];
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        unique case (func_r)
          gmc_pkg::FUNC_CLEAR: begin
            adj_clr   = 1'b1;
            depth_nxt = '0;
            done_nxt  = 1'b0;
            for (int i = 0; i < NV; i++) begin
              color_nxt[i] = '0;
            end
            state_nxt = S_REPLY;
          end
          gmc_pkg::FUNC_EDGE: begin
            adj_re    = 1'b1;
            adj_raddr = va_r;
            state_nxt = S_EDGE_A;
          end
          gmc_pkg::FUNC_NEXT: begin
            if (done_r) begin
              state_nxt = S_REPLY;
            end else begin
              if ({1'b0, depth_r} >= n_used) begin
                depth_nxt = n_last;
              end
              state_nxt = S_SRCH_RD;
            end
          end
          default: begin
            state_nxt = S_REPLY;
          end
        endcase
      end

      // row a gets bit b; row b is read in the same cycle (a self-loop sets one bit twice)
      S_EDGE_A: begin
        adj_we    = 1'b1;
        adj_waddr = va_r;
        adj_wdata = adj_rdata | (gmc_pkg::adj_row_t'(1) << vb_r);
        adj_re    = 1'b1;
        adj_raddr = vb_r;
        state_nxt = S_EDGE_B;
      end

      S_EDGE_B: begin
        adj_we    = 1'b1;
        adj_waddr = vb_r;
        adj_wdata = adj_rdata | (gmc_pkg::adj_row_t'(1) << va_r);
        depth_nxt = '0;
        done_nxt  = 1'b0;
        for (int i = 0; i < NV; i++) begin
          color_nxt[i] = '0;
        end
        state_nxt = S_REPLY;
      end

      S_SRCH_RD: begin
        adj_re    = 1'b1;
        adj_raddr = depth_r;
        state_nxt = S_SRCH_TRY;
      end

      // one color trial per cycle against the held neighbor row, unless a result waiting on out_tready holds the search
      S_SRCH_TRY: begin
        if (cand == '0) begin
          // out of colors: backtrack, or the whole tree is spent
          if (depth_r == '0) begin
            if (out_free) begin
              color_nxt[depth_r] = '0;
              done_nxt      = 1'b1;
              out_valid_nxt = 1'b1;
              found_nxt     = 1'b0;
              exh_nxt       = 1'b1;
              coloring_nxt  = '0;
              state_nxt     = S_IDLE;
            end
          end else begin
            color_nxt[depth_r] = '0;
            depth_nxt = depth_r - gmc_pkg::VTX_W'(1);
            state_nxt = S_SRCH_RD;
          end
        end else if (clash) begin
          color_nxt[depth_r] = cand;
        end else if (depth_r == n_last) begin
          // last vertex colored: report and leave the search parked here
          if (out_free) begin
            color_nxt[depth_r] = cand;
            out_valid_nxt = 1'b1;
            found_nxt     = 1'b1;
            exh_nxt       = 1'b0;
            coloring_nxt  = gmc_pkg::COLORING_W'(trial_colors);
            state_nxt     = S_IDLE;
          end
        end else begin
          color_nxt[depth_r] = cand;
          depth_nxt = depth_r + gmc_pkg::VTX_W'(1);
          state_nxt = S_SRCH_RD;
        end
      end

      // plain answer for clear, edge, unused code and a spent search
      S_REPLY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b0;
          exh_nxt       = done_r;
          coloring_nxt  = '0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // register writes restart the search
    if (cfg_we) begin
      unique case (cfg_index)
        gmc_pkg::CFG_NUM_VERTICES: num_vertices_nxt = cfg_wdata;
        gmc_pkg::CFG_NUM_COLORS:   num_colors_nxt   = cfg_wdata;
        default: ;
      endcase
      depth_nxt = '0;
      done_nxt  = 1'b0;
      for (int i = 0; i < NV; i++) begin
        color_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      num_vertices_r <= gmc_pkg::CFG_W'(8);
      num_colors_r   <= gmc_pkg::CFG_W'(3);
      depth_r        <= '0;
      done_r         <= 1'b0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < NV; i++) begin
        color_r[i] <= '0;
      end
    end else begin
      state_r        <= state_nxt;
      num_vertices_r <= num_vertices_nxt;
      num_colors_r   <= num_colors_nxt;
      depth_r        <= depth_nxt;
      done_r         <= done_nxt;
      out_valid_r    <= out_valid_nxt;
      for (int i = 0; i < NV; i++) begin
        color_r[i] <= color_nxt[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    va_r       <= va_nxt;
    vb_r       <= vb_nxt;
    found_r    <= found_nxt;
    exh_r      <= exh_nxt;
    coloring_r <= coloring_nxt;
  end

endmodule
